// ----- hw/rtl/png_chunk_locator_top_defines.svh -----
// Assertion macros for the PNG chunk locator.
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef PNG_CHUNK_LOCATOR_TOP_DEFINES_SVH
`define PNG_CHUNK_LOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define PCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pcl_pkg.sv -----
// Shared types and constants for the PNG chunk locator.
// No dependencies; imported by the parser and the top level.
package pcl_pkg;

  localparam int unsigned SIG_BYTES  = 8;
  localparam int unsigned TYPE_BYTES = 4;

  localparam logic [3:0]  POS_SAT       = 4'(SIG_BYTES + TYPE_BYTES - 1);
  localparam logic [1:0]  CRC_LAST      = 2'(TYPE_BYTES - 1);
  localparam logic [31:0] TARGET_RESET  = 32'h4948_4452;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_CRC    = 4'b0100,
    PH_DONE   = 4'b1000
  } pcl_phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } pcl_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] chunk_length;
    logic [31:0] chunk_crc;
  } pcl_result_t;

endpackage

// ----- hw/rtl/pcl_if.sv -----
// Valid/ready channel interfaces for the PNG chunk locator.
// pcl_in_if carries file bytes, pcl_out_if carries located-chunk results.
interface pcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output byte_value, output first_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input byte_value, input first_byte,
                  input last_byte, output ready);
endinterface

interface pcl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] chunk_length;
  logic [31:0] chunk_crc;

  modport source (output valid, output found, output chunk_length,
                  output chunk_crc, input ready);
  modport sink   (input valid, input found, input chunk_length,
                  input chunk_crc, output ready);
endinterface

// ----- hw/rtl/pcl_parse.sv -----
// Parse state of the PNG chunk locator: search, skip, CRC gather.
// Depends on pcl_pkg; one byte is consumed on each cycle that go is high.
module pcl_parse
  import pcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  pcl_item_t   item,
  input  logic [31:0] target,
  output logic        res_vld,
  output pcl_result_t res
);

  pcl_phase_t  phase_r,  phase_nxt;
  logic [3:0]  pos_r,    pos_nxt;
  logic [63:0] recent_r, recent_nxt;
  logic [31:0] held_r,   held_nxt;
  logic [31:0] rem_r,    rem_nxt;
  logic [31:0] crc_r,    crc_nxt;
  logic [1:0]  seen_r,   seen_nxt;

  pcl_phase_t  cur_phase;
  logic [3:0]  cur_pos;
  logic [63:0] cur_recent;
  logic [31:0] cur_held;
  logic [31:0] cur_rem;
  logic [31:0] cur_crc;
  logic [1:0]  cur_seen;
  logic        hit;
  logic        active;

  always_comb begin
    // a first mark restarts from the cleared state
    cur_phase  = item.first_byte ? PH_SEARCH : phase_r;
    cur_pos    = item.first_byte ? 4'd0  : pos_r;
    cur_recent = item.first_byte ? 64'd0 : recent_r;
    cur_held   = item.first_byte ? 32'd0 : held_r;
    cur_rem    = item.first_byte ? 32'd0 : rem_r;
    cur_crc    = item.first_byte ? 32'd0 : crc_r;
    cur_seen   = item.first_byte ? 2'd0  : seen_r;

    phase_nxt  = cur_phase;
    pos_nxt    = cur_pos;
    recent_nxt = cur_recent;
    held_nxt   = cur_held;
    rem_nxt    = cur_rem;
    crc_nxt    = cur_crc;
    seen_nxt   = cur_seen;
    hit        = 1'b0;
    active     = 1'b1;

    case (cur_phase)
      PH_SEARCH: begin
        recent_nxt = {cur_recent[55:0], item.byte_value};
        // chunk type must start at or after the end of the signature
        if (cur_pos >= POS_SAT && recent_nxt[31:0] == target) begin
          held_nxt  = recent_nxt[63:32];
          rem_nxt   = recent_nxt[63:32];
          crc_nxt   = 32'd0;
          seen_nxt  = 2'd0;
          phase_nxt = (recent_nxt[63:32] != 32'd0) ? PH_SKIP : PH_CRC;
        end
        if (cur_pos < POS_SAT) begin
          pos_nxt = cur_pos + 4'd1;
        end
      end
      PH_SKIP: begin
        rem_nxt = cur_rem - 32'd1;
        if (rem_nxt == 32'd0) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_nxt = {cur_crc[23:0], item.byte_value};
        if (cur_seen == CRC_LAST) begin
          hit       = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          seen_nxt = cur_seen + 2'd1;
        end
      end
      default: begin
        active = 1'b0;
      end
    endcase

    if (!hit && active && item.last_byte) begin
      phase_nxt = PH_DONE;
    end

    res_vld          = hit || (active && item.last_byte);
    res.found        = hit;
    res.chunk_length = hit ? held_nxt : 32'd0;
    res.chunk_crc    = hit ? crc_nxt  : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      pos_r    <= 4'd0;
      recent_r <= 64'd0;
      held_r   <= 32'd0;
      rem_r    <= 32'd0;
      crc_r    <= 32'd0;
      seen_r   <= 2'd0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      recent_r <= recent_nxt;
      held_r   <= held_nxt;
      rem_r    <= rem_nxt;
      crc_r    <= crc_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

// ----- hw/rtl/png_chunk_locator_top.sv -----
// PNG chunk locator, top level.
// in_byte takes one file byte per transaction with first/last markers; the
// first marker restarts the parse. After the 8-byte signature the block looks
// for the configured four-byte chunk type, reads the length before it, skips
// the data and returns the big-endian CRC on out_res with found=1. If the
// last byte arrives first, one transaction with found=0 and zero fields.
// cfg_we/cfg_wdata write the chunk type; reset value is "IHDR".
// Throughput: one byte per cycle unless out_res stalls a result, set by the
// single parse step between the input register and the result register.
// A byte completing a result is held in the input register, and the parse
// step then loads the result into the result register that drives out_res.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to search; bytes without a first marker then start a new file.
// When out_res stalls, bytes that make no result keep flowing; a byte that
// would make a second result waits in the input register and in_byte drops
// ready until the pending result is taken.
`include "png_chunk_locator_top_defines.svh"

module png_chunk_locator_top
  import pcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pcl_in_if.sink      in_byte,
  pcl_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] target_r;
  logic        in_vld_r;
  pcl_item_t   item_r;
  logic        out_vld_r;
  pcl_result_t res_r;

  logic        proc_go;
  logic        out_stall;
  logic        res_vld;
  pcl_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  // advance the held byte unless it makes a result that cannot be stored
  assign out_stall     = out_vld_r && !out_res.ready;
  assign proc_go       = in_vld_r && (!res_vld || !out_stall);
  assign in_byte.ready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_byte.ready) begin
      in_vld_r <= in_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.ready && in_byte.valid) begin
      item_r.byte_value <= in_byte.byte_value;
      item_r.first_byte <= in_byte.first_byte;
      item_r.last_byte  <= in_byte.last_byte;
    end
  end

  pcl_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (proc_go),
    .item    (item_r),
    .target  (target_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_vld) begin
      res_r <= res;
    end
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.found        = res_r.found;
  assign out_res.chunk_length = res_r.chunk_length;
  assign out_res.chunk_crc    = res_r.chunk_crc;

  `PCL_ASSERT_NOW(a_no_overwrite, in_vld_r && res_vld && out_stall, !proc_go, "result lost")
  `PCL_ASSERT_NEXT(a_result_loaded, proc_go && res_vld, out_vld_r, "result not presented")
  `PCL_ASSERT_NOW(a_empty_ready, !in_vld_r, in_byte.ready, "empty input stalls")
  `PCL_ASSERT_NOW(a_miss_zero, out_vld_r && !res_r.found, res_r == '0, "nonzero miss fields")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for png_chunk_locator_top: feeds PNG-like byte files,
// predicts each located-chunk result and compares it on out_res.
// Depends on pcl_pkg, pcl_in_if/pcl_out_if and the RTL under hw/rtl.
module tb_top;
  import pcl_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 275;
  localparam logic [63:0] PNG_SIG     = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IDAT   = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND   = 32'h4945_4E44;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  pcl_in_if  in_ch ();
  pcl_out_if out_ch ();

  png_chunk_locator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pcl_item_t   byte_q[$];
  pcl_result_t chunk_q[$];
  logic [7:0]  file_buf[$];

  int bytes_pushed;
  int bytes_taken;
  int fail_count;
  int found_seen;
  int missed_seen;
  int files_built;
  int phase_items;
  int stall_cycles;
  bit steady;

  // parser shadow
  pcl_phase_t  scan_phase  = PH_SEARCH;
  logic [3:0]  file_pos    = '0;
  logic [63:0] window      = '0;
  logic [31:0] len_hold    = '0;
  logic [31:0] skip_left   = '0;
  logic [31:0] crc_acc     = '0;
  logic [1:0]  crc_count   = '0;
  logic [31:0] type_sought = TARGET_RESET;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Append one byte to the file under construction.
  task automatic add_file_byte(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endtask

  // Advance the shadow parser by one accepted byte and queue any result.
  task automatic track_byte(input pcl_item_t it);
    logic        hit;
    pcl_result_t res;
    hit = 1'b0;
    if (it.first_byte) begin
      scan_phase = PH_SEARCH;
      file_pos   = '0;
      window     = '0;
      len_hold   = '0;
      skip_left  = '0;
      crc_acc    = '0;
      crc_count  = '0;
    end
    if (scan_phase == PH_DONE) return;
    case (scan_phase)
      PH_SEARCH: begin
        window = {window[55:0], it.byte_value};
        // type field must start at offset 8 or later
        if (file_pos >= POS_SAT && window[31:0] == type_sought) begin
          len_hold   = window[63:32];
          skip_left  = len_hold;
          crc_acc    = '0;
          crc_count  = '0;
          scan_phase = (len_hold != 0) ? PH_SKIP : PH_CRC;
        end
        if (file_pos < POS_SAT) file_pos = file_pos + 1'b1;
      end
      PH_SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) scan_phase = PH_CRC;
      end
      default: begin
        crc_acc = {crc_acc[23:0], it.byte_value};
        if (crc_count == CRC_LAST) begin
          hit        = 1'b1;
          scan_phase = PH_DONE;
        end else begin
          crc_count = crc_count + 1'b1;
        end
      end
    endcase
    if (hit) begin
      res.found        = 1'b1;
      res.chunk_length = len_hold;
      res.chunk_crc    = crc_acc;
      chunk_q.insert(chunk_q.size(), res);
    end else if (it.last_byte) begin
      scan_phase = PH_DONE;
      res        = '0;
      chunk_q.insert(chunk_q.size(), res);
    end
  endtask

  // Byte driver: hold the item until accepted, idle now and then.
  always @(posedge clk) begin
    pcl_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.byte_value = in_ch.byte_value;
        nxt.first_byte = in_ch.first_byte;
        nxt.last_byte  = in_ch.last_byte;
        track_byte(nxt);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
          nxt = byte_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.byte_value <= nxt.byte_value;
          in_ch.first_byte <= nxt.first_byte;
          in_ch.last_byte  <= nxt.last_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random back-pressure.
  always @(posedge clk) begin
    pcl_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 12);
      if (out_ch.valid && out_ch.ready) begin
        if (chunk_q.size() == 0) begin
          $error("unexpected result transaction: found=%0d length=%h crc=%h",
                 out_ch.found, out_ch.chunk_length, out_ch.chunk_crc);
          fail_count++;
        end else begin
          want = chunk_q.pop_front();
          if (want.found) found_seen++;
          else missed_seen++;
          if (out_ch.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_ch.found);
            fail_count++;
          end
          if (out_ch.chunk_length !== want.chunk_length) begin
            $error("chunk_length: expected %h, actual %h",
                   want.chunk_length, out_ch.chunk_length);
            fail_count++;
          end
          if (out_ch.chunk_crc !== want.chunk_crc) begin
            $error("chunk_crc: expected %h, actual %h", want.chunk_crc, out_ch.chunk_crc);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL png_chunk_locator_top");
        $finish;
      end
    end
  end

  task automatic put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) add_file_byte(w[31 - 8 * k -: 8]);
  endtask

  task automatic put_random(input int n);
    for (int k = 0; k < n; k++) add_file_byte(8'($urandom()));
  endtask

  function automatic logic [31:0] pick_type();
    int r;
    r = $urandom_range(99);
    if (r < 40) return type_sought;
    if (r < 60) return $urandom();
    if (r < 75) return TYPE_IDAT;
    if (r < 88) return TYPE_IEND;
    return TARGET_RESET;
  endfunction

  task automatic put_chunk();
    logic [31:0] len;
    len = ($urandom_range(99) < 10) ? 32'($urandom()) : 32'($urandom_range(10));
    put_word(len);
    put_word(pick_type());
    // huge lengths never finish; a few data bytes are enough
    put_random((len > 64) ? $urandom_range(16) : int'(len));
    put_word($urandom());
  endtask

  task automatic put_signature();
    if ($urandom_range(99) < 85) begin
      put_word(PNG_SIG[63:32]);
      put_word(PNG_SIG[31:0]);
    end else begin
      put_random(8);
    end
  endtask

  task automatic cut_file();
    int keep;
    keep = $urandom_range(file_buf.size(), 1);
    while (file_buf.size() > keep) void'(file_buf.pop_back());
  endtask

  // Move the file buffer into the byte queue with its marks.
  task automatic emit_file(input bit mark_first, input bit mark_last, input bit counted);
    pcl_item_t it;
    foreach (file_buf[k]) begin
      it.byte_value = file_buf[k];
      it.first_byte = mark_first && (k == 0);
      it.last_byte  = mark_last && (k == file_buf.size() - 1);
      byte_q.insert(byte_q.size(), it);
    end
    bytes_pushed += file_buf.size();
    if (counted) phase_items += file_buf.size();
    files_built++;
    file_buf.delete();
  endtask

  task automatic random_file();
    int kind;
    int nchunks;
    kind = $urandom_range(99);
    if (kind < 62) begin
      put_signature();
      nchunks = $urandom_range(4, 1);
      for (int c = 0; c < nchunks; c++) put_chunk();
      if ($urandom_range(99) < 25) cut_file();
      emit_file(1'b1, 1'b1, 1'b1);
    end else if (kind < 74) begin
      // type right after the signature: length comes from signature bytes
      put_word(PNG_SIG[63:32]);
      put_word($urandom_range(1) ? PNG_SIG[31:0] : 32'($urandom_range(3)));
      put_word(type_sought);
      put_random($urandom_range(8));
      emit_file(1'b1, 1'b1, 1'b1);
    end else if (kind < 88) begin
      put_random($urandom_range(16, 1));
      if ($urandom_range(1)) put_word(type_sought);
      put_random($urandom_range(12));
      emit_file(1'b1, 1'b1, 1'b1);
    end else if (kind < 94) begin
      // no last mark: the next first mark restarts the parse
      put_signature();
      put_chunk();
      cut_file();
      emit_file(1'b1, 1'b0, 1'b1);
    end else begin
      put_random($urandom_range(4, 1));
      emit_file(1'b0, $urandom_range(1), 1'b0);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (bytes_taken != bytes_pushed || chunk_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_type(input logic [31:0] value);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    type_sought = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] setting, input bit do_write, input bit calm);
    if (do_write) write_type(setting);
    @(negedge clk);
    steady      = calm;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) random_file();
    drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.byte_value = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    steady           = 1'b0;
    bytes_pushed     = 0;
    bytes_taken      = 0;
    fail_count       = 0;
    found_seen       = 0;
    missed_seen      = 0;
    files_built      = 0;
    stall_cycles     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unmarked bytes after reset parse as a file; last byte completes the CRC
    put_word(PNG_SIG[63:32]);
    put_word(PNG_SIG[31:0]);
    put_word(32'h0);
    put_word(TARGET_RESET);
    put_word(32'hFF00_00FF);
    emit_file(1'b0, 1'b1, 1'b1);
    // single-byte file, then stray bytes that must be dropped
    add_file_byte(8'hFF);
    emit_file(1'b1, 1'b1, 1'b1);
    add_file_byte(8'h00);
    add_file_byte(8'h5A);
    emit_file(1'b0, 1'b0, 1'b0);
    drain();

    run_phase(TARGET_RESET, 1'b0, 1'b0);
    run_phase(32'h0000_0000, 1'b1, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 1'b1);
    run_phase(TYPE_IDAT, 1'b1, 1'b0);
    run_phase($urandom(), 1'b1, 1'b0);
    run_phase(TARGET_RESET, 1'b1, 1'b0);

    $display("Streamed %0d bytes in %0d files across six chunk-type settings",
             bytes_taken, files_built);
    $display("Checked %0d located chunks and %0d files that ended before a full CRC",
             found_seen, missed_seen);
    if (fail_count == 0) begin
      $display("PASS png_chunk_locator_top");
    end else begin
      $display("FAIL png_chunk_locator_top");
    end
    $finish;
  end

endmodule
